### hw/rtl/i8080s_pkg.sv
// Package: types, opcodes and codes for the 8080 subset executor.
package i8080s_pkg;

    localparam int MEM_DEPTH_DEF = 65536;

    typedef enum logic [1:0] {
        CMD_MEM_WR  = 2'd0,
        CMD_MEM_RD  = 2'd1,
        CMD_REG_WR  = 2'd2,
        CMD_EXEC    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FAULT  = 2'd1,
        ST_REFUSE = 2'd2
    } status_t;

    localparam logic [3:0] RI_A = 4'd0, RI_B = 4'd1, RI_C = 4'd2, RI_D = 4'd3,
        RI_E = 4'd4, RI_H = 4'd5, RI_L = 4'd6, RI_SP = 4'd7, RI_PC = 4'd8,
        RI_FL = 4'd9;

    localparam logic [7:0] OP_NOP = 8'h00, OP_LXIB = 8'h01, OP_RRC = 8'h0f,
        OP_RAR = 8'h1f, OP_CMA = 8'h2f, OP_MOVBC = 8'h41, OP_MOVBD = 8'h42,
        OP_MOVBE = 8'h43, OP_ADDB = 8'h80, OP_ADDC = 8'h81, OP_ADDM = 8'h86,
        OP_ADI = 8'hc6, OP_ANI = 8'he6, OP_CPI = 8'hfe, OP_POPB = 8'hc1,
        OP_PUSHB = 8'hc5, OP_POPPSW = 8'hf1, OP_PUSHPSW = 8'hf5, OP_JNZ = 8'hc2,
        OP_JMP = 8'hc3, OP_CALL = 8'hcd, OP_RET = 8'hc9;

    localparam int FZ = 0, FS = 1, FP = 2, FC = 3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE, S_DBG_RD, S_FETCH, S_B1, S_B2, S_DECODE, S_MEMOP,
        S_POP_LO, S_POP_HI, S_PUSH_HI, S_PUSH_LO, S_FINISH, S_OUT
    } state_t;

    // ALU operation select
    typedef enum logic [1:0] {
        ALU_ADD, ALU_AND, ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [7:0] res;
        logic [4:0] flags;
    } alu_res_t;

endpackage

### hw/rtl/i8080s_alu.sv
// Shared 8-bit add / and / compare unit with flag generation.
module i8080s_alu (
    input  i8080s_pkg::alu_op_t  op,
    input  logic [7:0]           a,
    input  logic [7:0]           b,
    input  logic [4:0]           flags_in,
    output i8080s_pkg::alu_res_t out
);
    import i8080s_pkg::*;

    logic [8:0] sum;
    logic       cy;

    always_comb
    begin
        case (op)
            ALU_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                cy  = sum[8];
            end
            ALU_AND:
            begin
                sum = {1'b0, a & b};
                cy  = 1'b0;
            end
            ALU_SUB:
            begin
                sum = {1'b0, a} - {1'b0, b};
                cy  = (a < b);
            end
            default:
            begin
                sum = 9'd0;
                cy  = 1'b0;
            end
        endcase
        out.res       = sum[7:0];
        out.flags     = {flags_in[4], 4'd0};
        out.flags[FZ] = (sum[7:0] == 8'd0);
        out.flags[FS] = sum[7];
        out.flags[FP] = ~^sum[7:0];
        out.flags[FC] = cy;
    end

endmodule

### hw/rtl/i8080_subset_executor.sv
// Top level: 8080 subset executor with internal memory and debug commands.
//
// Usage: each input transaction on s_axis carries a command in tdata:
// memory write, memory read, register write or execute one instruction.
// Exactly one result transaction follows on m_axis, holding the read byte,
// registers A, B, C, H and L, pc, sp, flags and a status code.
// Steps, from the accepting edge to m_axis_tvalid: register and memory
// writes and refused executes go straight to output; memory reads pass a read
// and a finish state. An instruction fetches the opcode and two operand bytes,
// decodes, finishes and outputs; ADD M adds one data byte access, PUSH, POP,
// CALL and RET two stack byte accesses, all through the single memory port.
// One item in flight; s_axis_tready is high only while the
// sequencer is idle and no result is waiting.
// The result register holds until m_axis_tready; the next item is not
// taken until the result has left.
// Reset clears all registers, pc, sp, flags and the fault latch; memory
// content is undefined until written. An unknown opcode latches a fault;
// later executes answer "refused" until pc is written.
module i8080_subset_executor #(
    parameter int MEM_DEPTH = i8080s_pkg::MEM_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: command[1:0], address[17:2], value[33:18], zero pad to 40
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: read_data[7:0], acc_out[15:8], reg_b_out[23:16], reg_c_out[31:24],
    // reg_h_out[39:32], reg_l_out[47:40], pc_out[63:48], sp_out[79:64],
    // flags_out[84:80], status[86:85], zero pad to 88
    output logic [87:0] m_axis_tdata
);
    import i8080s_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // architectural registers
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [15:0] sp_reg, pc_reg;
    logic [4:0]  fl_reg;
    logic        fault_reg;
    // sequencer registers
    state_t      st_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg, val_reg;
    logic [7:0]  op_reg, b1_reg, b2_reg, tmp_reg;
    logic [7:0]  rd_reg;
    logic [1:0]  status_reg;
    logic        out_v_reg;
    logic [87:0] out_reg;

    // memory port
    logic [7:0]  mem [0:MEM_DEPTH-1];
    logic [7:0]  mem_q;
    logic [15:0] m_addr;
    logic        m_we;
    logic [7:0]  m_wd;

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem[m_addr[AW-1:0]] <= m_wd;
        mem_q <= mem[m_addr[AW-1:0]];
    end

    // shared ALU
    alu_op_t  alu_op;
    logic [7:0] alu_b;
    alu_res_t alu_o;

    i8080s_alu u_alu (
        .op(alu_op), .a(a_reg), .b(alu_b), .flags_in(fl_reg), .out(alu_o)
    );

    assign s_axis_tready = (st_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

    wire in_fire = s_axis_tvalid && s_axis_tready;

    logic known;
    always_comb
    begin
        case (op_reg)
            OP_NOP, OP_LXIB, OP_RRC, OP_RAR, OP_CMA, OP_MOVBC, OP_MOVBD,
            OP_MOVBE, OP_ADDB, OP_ADDC, OP_ADDM, OP_ADI, OP_ANI, OP_CPI,
            OP_POPB, OP_PUSHB, OP_POPPSW, OP_PUSHPSW, OP_JNZ, OP_JMP,
            OP_CALL, OP_RET: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    wire [15:0] target = {b2_reg, b1_reg};
    wire [15:0] ret_pc = pc_reg + 16'd2;

    // pc after the instruction; an unknown opcode keeps pc
    logic [15:0] exec_pc;
    always_comb
    begin
        case (op_reg)
            OP_LXIB:                 exec_pc = pc_reg + 16'd3;
            OP_ADI, OP_ANI, OP_CPI:  exec_pc = pc_reg + 16'd2;
            OP_RET:                  exec_pc = {mem_q, tmp_reg} + 16'd1;
            OP_JNZ:                  exec_pc = fl_reg[FZ] ? pc_reg + 16'd3 : target;
            OP_JMP, OP_CALL:         exec_pc = target;
            default:                 exec_pc = known ? pc_reg + 16'd1 : pc_reg;
        endcase
    end

    // address and write selection per state, ALU selection per opcode
    always_comb
    begin
        m_addr = addr_reg;
        m_we   = 1'b0;
        m_wd   = val_reg[7:0];
        alu_op = ALU_ADD;
        alu_b  = b_reg;
        case (st_reg)
            S_IDLE:
            begin
                m_addr = s_axis_tdata[17:2];
                m_we   = in_fire && (s_axis_tdata[1:0] == CMD_MEM_WR);
                m_wd   = s_axis_tdata[25:18];
            end
            S_FETCH:   m_addr = pc_reg;
            S_B1:      m_addr = pc_reg + 16'd1;
            S_B2:      m_addr = pc_reg + 16'd2;
            S_DECODE, S_MEMOP: m_addr = {h_reg, l_reg};
            S_POP_LO:  m_addr = sp_reg;
            S_POP_HI:  m_addr = sp_reg + 16'd1;
            S_PUSH_HI:
            begin
                m_addr = sp_reg - 16'd1;
                m_we   = 1'b1;
                case (op_reg)
                    OP_PUSHB:   m_wd = b_reg;
                    OP_PUSHPSW: m_wd = a_reg;
                    default:    m_wd = ret_pc[15:8];
                endcase
            end
            S_PUSH_LO:
            begin
                m_addr = sp_reg - 16'd2;
                m_we   = 1'b1;
                case (op_reg)
                    OP_PUSHB:   m_wd = c_reg;
                    OP_PUSHPSW: m_wd = {3'd0, fl_reg};
                    default:    m_wd = ret_pc[7:0];
                endcase
            end
            default: ;
        endcase
        case (op_reg)
            OP_ADDC: alu_b = c_reg;
            OP_ADDM: alu_b = mem_q;
            OP_ADI:  alu_b = b1_reg;
            OP_ANI:  begin alu_b = b1_reg; alu_op = ALU_AND; end
            OP_CPI:  begin alu_b = b1_reg; alu_op = ALU_SUB; end
            default: ;
        endcase
    end

    // sequencer and register updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; out_v_reg <= 1'b0; fault_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
            h_reg <= '0; l_reg <= '0; sp_reg <= '0; pc_reg <= '0; fl_reg <= '0;
        end
        else
        begin
            if (out_v_reg && m_axis_tready)
                out_v_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        cmd_reg    <= s_axis_tdata[1:0];
                        addr_reg   <= s_axis_tdata[17:2];
                        val_reg    <= s_axis_tdata[33:18];
                        rd_reg     <= 8'd0;
                        status_reg <= (s_axis_tdata[1:0] == CMD_EXEC && fault_reg) ?
                                      ST_REFUSE : ST_DONE;
                        case (s_axis_tdata[1:0])
                            CMD_MEM_RD: st_reg <= S_DBG_RD;
                            CMD_EXEC:   st_reg <= fault_reg ? S_OUT : S_FETCH;
                            CMD_REG_WR:
                            begin
                                case (s_axis_tdata[17:2])
                                    16'(RI_A):  a_reg <= s_axis_tdata[25:18];
                                    16'(RI_B):  b_reg <= s_axis_tdata[25:18];
                                    16'(RI_C):  c_reg <= s_axis_tdata[25:18];
                                    16'(RI_D):  d_reg <= s_axis_tdata[25:18];
                                    16'(RI_E):  e_reg <= s_axis_tdata[25:18];
                                    16'(RI_H):  h_reg <= s_axis_tdata[25:18];
                                    16'(RI_L):  l_reg <= s_axis_tdata[25:18];
                                    16'(RI_SP): sp_reg <= s_axis_tdata[33:18];
                                    16'(RI_PC):
                                    begin
                                        pc_reg    <= s_axis_tdata[33:18];
                                        fault_reg <= 1'b0;
                                    end
                                    16'(RI_FL): fl_reg <= s_axis_tdata[22:18];
                                    default: ;
                                endcase
                                st_reg <= S_OUT;
                            end
                            default: st_reg <= S_OUT;
                        endcase
                    end
                S_DBG_RD: st_reg <= S_FINISH;
                S_FETCH:  st_reg <= S_B1;
                S_B1:
                begin
                    op_reg <= mem_q;
                    st_reg <= S_B2;
                end
                S_B2:
                begin
                    b1_reg <= mem_q;
                    st_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    b2_reg <= mem_q;
                    case (op_reg)
                        OP_ADDM:                     st_reg <= S_MEMOP;
                        OP_POPB, OP_POPPSW, OP_RET:  st_reg <= S_POP_LO;
                        OP_PUSHB, OP_PUSHPSW, OP_CALL: st_reg <= S_PUSH_HI;
                        default:                     st_reg <= S_FINISH;
                    endcase
                end
                S_MEMOP:   st_reg <= S_FINISH;
                S_POP_LO:  st_reg <= S_POP_HI;
                S_POP_HI:
                begin
                    tmp_reg <= mem_q;
                    st_reg  <= S_FINISH;
                end
                S_PUSH_HI: st_reg <= S_PUSH_LO;
                S_PUSH_LO:
                begin
                    sp_reg <= sp_reg - 16'd2;
                    st_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    st_reg <= S_OUT;
                    if (cmd_reg == CMD_MEM_RD)
                        rd_reg <= mem_q;
                    else
                    begin
                        pc_reg <= exec_pc;
                        case (op_reg)
                            OP_LXIB:
                            begin
                                c_reg <= b1_reg; b_reg <= b2_reg;
                            end
                            OP_RRC:
                            begin
                                a_reg <= {a_reg[0], a_reg[7:1]};
                                fl_reg[FC] <= a_reg[0];
                            end
                            OP_RAR:
                            begin
                                a_reg <= {fl_reg[FC], a_reg[7:1]};
                                fl_reg[FC] <= a_reg[0];
                            end
                            OP_CMA: a_reg <= ~a_reg;
                            OP_MOVBC: b_reg <= c_reg;
                            OP_MOVBD: b_reg <= d_reg;
                            OP_MOVBE: b_reg <= e_reg;
                            OP_ADDB, OP_ADDC, OP_ADDM, OP_ADI, OP_ANI:
                            begin
                                a_reg <= alu_o.res; fl_reg <= alu_o.flags;
                            end
                            OP_CPI: fl_reg <= alu_o.flags;
                            OP_POPB:
                            begin
                                c_reg <= tmp_reg; b_reg <= mem_q;
                                sp_reg <= sp_reg + 16'd2;
                            end
                            OP_POPPSW:
                            begin
                                fl_reg <= tmp_reg[4:0]; a_reg <= mem_q;
                                sp_reg <= sp_reg + 16'd2;
                            end
                            OP_RET: sp_reg <= sp_reg + 16'd2;
                            OP_NOP, OP_PUSHB, OP_PUSHPSW, OP_JNZ, OP_JMP, OP_CALL: ;
                            default:
                            begin
                                fault_reg  <= 1'b1;
                                status_reg <= ST_FAULT;
                            end
                        endcase
                    end
                end
                S_OUT:
                    if (!out_v_reg)
                    begin
                        out_reg <= {1'b0, status_reg, fl_reg, sp_reg, pc_reg,
                                    l_reg, h_reg, c_reg, b_reg, a_reg, rd_reg};
                        out_v_reg <= 1'b1;
                        st_reg    <= S_IDLE;
                    end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !s_axis_tready)
        else $error("accepted while busy");
    a_fault_status: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_FINISH && cmd_reg == CMD_EXEC && !known) |=> fault_reg)
        else $error("fault not latched");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !m_axis_tready) |=> $stable(out_reg))
        else $error("result changed under stall");
    a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_PUSH_LO) |=> (sp_reg == $past(sp_reg) - 16'd2))
        else $error("push sp");

endmodule
